@@ rtl/fsd_pkg.sv @@
// Package for the Floyd-Steinberg palette ditherer: sizes, word types, sequencer states.
package fsd_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int PALETTE_DEPTH = 256;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int PIW = $clog2(PALETTE_DEPTH);
    localparam int WW  = (XW + 1 > 13) ? XW + 1 : 13;

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PALETTE_SIZE = 2'd2;

    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_PIXEL   = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } fsd_in_t;

    typedef struct packed {
        logic [7:0] palette_index;
        logic       row_end;
        logic       image_end;
    } fsd_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEARCH,
        ST_DRAIN,
        ST_ERR,
        ST_WR2,
        ST_DONE
    } fsd_state_t;

endpackage

@@ rtl/floyd_steinberg_palette_dither_top.sv @@
// Floyd-Steinberg error-diffusion quantizer to a programmable RGB palette.
// A palette write word is taken while the sequencer stays idle. A pixel word keeps the
// input closed through the error-line read, the nearest-color search, the error update
// and, at the last pixel of a row, a second error-line write. The search reads the
// effective palette, one entry per cycle, from the palette RAM through a three-stage
// distance/compare pipe. A finished index waits in the output register while the next
// word is taken; a pixel whose index finds that register still full holds in its last
// cycle until the register drains.
module floyd_steinberg_palette_dither_top
    import fsd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsd_in_t             s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fsd_out_t            m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    function automatic logic signed [8:0] share(logic signed [8:0] e, logic [3:0] k);
        logic signed [12:0] p;
        p = 13'(e) * $signed({9'b0, k});
        if (p < 0) begin
            p = p + 13'sd15;
        end
        return 9'(p >>> 4);
    endfunction

    fsd_state_t state_reg, state_next;

    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [8:0]  psize_reg;

    logic [23:0] pal_mem [PALETTE_DEPTH];
    logic [26:0] err_mem [MAX_WIDTH];

    logic [XW-1:0] col_reg;
    logic [15:0]   row_reg;

    logic [7:0]        pix_reg   [3];
    logic [7:0]        c_reg     [3];
    logic signed [7:0] rc_reg    [3];
    logic signed [8:0] bp0_reg   [3];
    logic signed [8:0] bp1_reg   [3];
    logic signed [8:0] cur_reg   [3];
    logic [26:0]       err_q_reg;

    logic [8:0]     issue_reg;
    logic           a_valid_reg, b_valid_reg;
    logic [PIW-1:0] a_idx_reg, b_idx_reg;
    logic [23:0]    pal_q_reg, b_rgb_reg;
    logic [16:0]    sq_reg [3];
    logic           first_reg;
    logic [17:0]    best_d_reg;
    logic [PIW-1:0] best_idx_reg;
    logic [23:0]    best_rgb_reg;

    logic     m_valid_reg;
    fsd_out_t m_data_reg;

    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic [8:0]    n_eff;
    logic [XW-1:0] x_cur;
    logic          last_col, last_row;

    logic           accept;
    logic           issue;
    logic           load_out;
    logic           err_we;
    logic [XW-1:0]  err_wa;
    logic [26:0]    err_wd;

    logic signed [8:0] e_ch   [3];
    logic signed [8:0] s3_ch  [3];
    logic signed [8:0] s5_ch  [3];
    logic signed [8:0] s7_ch  [3];
    logic signed [8:0] s1_ch  [3];
    logic signed [8:0] cur_ch [3];
    logic signed [8:0] left_ch[3];
    logic [16:0]       sq_ch  [3];
    logic [17:0]       d_sum;

    // effective configuration and position
    always_comb begin
        if (width_reg == 13'd0) begin
            w_eff = WW'(1);
        end else if (WW'(width_reg) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
        if (psize_reg == 9'd0) begin
            n_eff = 9'd1;
        end else if (psize_reg > 9'(PALETTE_DEPTH)) begin
            n_eff = 9'(PALETTE_DEPTH);
        end else begin
            n_eff = psize_reg;
        end
        if (WW'(col_reg) >= w_eff) begin
            x_cur = XW'(w_eff - WW'(1));
        end else begin
            x_cur = col_reg;
        end
        last_col = (WW'(col_reg) + WW'(1)) >= w_eff;
        last_row = (17'(row_reg) + 17'd1) >= 17'(h_eff);
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        err_we     = 1'b0;
        err_wa     = x_cur - XW'(1);
        err_wd     = {left_ch[0], left_ch[1], left_ch[2]};
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_data.cmd == CMD_PIXEL) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                issue = 1'b1;
                if (issue_reg + 9'd1 >= n_eff) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!a_valid_reg && !b_valid_reg) begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                err_we     = (x_cur != '0);
                state_next = last_col ? ST_WR2 : ST_DONE;
            end
            ST_WR2: begin
                err_we     = 1'b1;
                err_wa     = x_cur;
                err_wd     = {cur_reg[0], cur_reg[1], cur_reg[2]};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    // memories
    always_ff @(posedge aclk) begin
        if (accept && s_data.cmd == CMD_PALETTE
                && 9'(s_data.entry_index) < 9'(PALETTE_DEPTH)) begin
            pal_mem[PIW'(s_data.entry_index)] <= {s_data.red, s_data.green, s_data.blue};
        end
        pal_q_reg <= pal_mem[PIW'(issue_reg)];
    end

    always_ff @(posedge aclk) begin
        if (err_we) begin
            err_mem[err_wa] <= err_wd;
        end
        err_q_reg <= err_mem[x_cur];
    end

    // error arithmetic
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            e_ch[ch]    = $signed({1'b0, c_reg[ch]})
                        - $signed({1'b0, best_rgb_reg[(2-ch)*8 +: 8]});
            s1_ch[ch]   = share(e_ch[ch], 4'd1);
            s3_ch[ch]   = share(e_ch[ch], 4'd3);
            s5_ch[ch]   = share(e_ch[ch], 4'd5);
            s7_ch[ch]   = share(e_ch[ch], 4'd7);
            cur_ch[ch]  = bp1_reg[ch] + s5_ch[ch];
            left_ch[ch] = bp0_reg[ch] + s3_ch[ch];
        end
    end

    // distance of the entry in stage A
    always_comb begin
        logic signed [8:0]  dd;
        logic signed [17:0] prod;
        for (int ch = 0; ch < 3; ch++) begin
            dd        = $signed({1'b0, c_reg[ch]}) - $signed({1'b0, pal_q_reg[(2-ch)*8 +: 8]});
            prod      = dd * dd;
            sq_ch[ch] = prod[16:0];
        end
        d_sum = 18'(sq_reg[0]) + 18'(sq_reg[1]) + 18'(sq_reg[2]);
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            first_reg   <= 1'b0;
            issue_reg   <= '0;
            for (int ch = 0; ch < 3; ch++) begin
                rc_reg[ch]  <= '0;
                bp0_reg[ch] <= '0;
                bp1_reg[ch] <= '0;
            end
        end else begin
            a_valid_reg <= issue;
            a_idx_reg   <= PIW'(issue_reg);
            b_valid_reg <= a_valid_reg;
            b_idx_reg   <= a_idx_reg;
            b_rgb_reg   <= pal_q_reg;
            for (int ch = 0; ch < 3; ch++) begin
                sq_reg[ch] <= sq_ch[ch];
            end
            if (accept) begin
                pix_reg[0] <= s_data.red;
                pix_reg[1] <= s_data.green;
                pix_reg[2] <= s_data.blue;
            end
            if (state_reg == ST_LOAD) begin
                issue_reg <= '0;
                first_reg <= 1'b1;
                for (int ch = 0; ch < 3; ch++) begin
                    logic signed [10:0] v;
                    v = $signed({3'b0, pix_reg[ch]}) + 11'(rc_reg[ch]);
                    if (row_reg != 16'd0) begin
                        v = v + 11'($signed(err_q_reg[(2-ch)*9 +: 9]));
                    end
                    if (v < 0) begin
                        c_reg[ch] <= 8'd0;
                    end else if (v > 11'sd255) begin
                        c_reg[ch] <= 8'd255;
                    end else begin
                        c_reg[ch] <= v[7:0];
                    end
                end
            end
            if (issue) begin
                issue_reg <= issue_reg + 9'd1;
            end
            if (b_valid_reg && (first_reg || d_sum < best_d_reg)) begin
                first_reg    <= 1'b0;
                best_d_reg   <= d_sum;
                best_idx_reg <= b_idx_reg;
                best_rgb_reg <= b_rgb_reg;
            end
            if (state_reg == ST_ERR) begin
                for (int ch = 0; ch < 3; ch++) begin
                    cur_reg[ch] <= cur_ch[ch];
                    if (last_col) begin
                        rc_reg[ch]  <= '0;
                        bp0_reg[ch] <= '0;
                        bp1_reg[ch] <= '0;
                    end else begin
                        rc_reg[ch]  <= 8'(s7_ch[ch]);
                        bp0_reg[ch] <= cur_ch[ch];
                        bp1_reg[ch] <= s1_ch[ch];
                    end
                end
            end
            if (load_out) begin
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? 16'd0 : row_reg + 16'd1;
                end else begin
                    col_reg <= col_reg + XW'(1);
                end
            end
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg.palette_index <= 8'(best_idx_reg);
            m_data_reg.row_end       <= last_col;
            m_data_reg.image_end     <= last_col && last_row;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd640;
            height_reg <= 16'd480;
            psize_reg  <= 9'd16;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[12:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[15:0];
                REG_PALETTE_SIZE: psize_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = {19'd0, width_reg};
            REG_IMAGE_HEIGHT: prdata = {16'd0, height_reg};
            REG_PALETTE_SIZE: prdata = {23'd0, psize_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

endmodule

@@ tb/sv/tb_floyd_steinberg_palette_dither_top.sv @@
// Testbench for the Floyd-Steinberg palette ditherer: directed and random pixel streams.
`timescale 1ns / 100ps

module tb_floyd_steinberg_palette_dither_top;
    import fsd_pkg::*;

    localparam int DRAIN_CYCLES = PALETTE_DEPTH + 40;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    fsd_in_t            s_data;
    logic               m_valid;
    logic               m_ready = 1'b0;
    fsd_out_t           m_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // shadow copy of the ditherer state
    logic [7:0]  pal_rgb [PALETTE_DEPTH][3];
    int          err_row [MAX_WIDTH][3];
    int          carry_right [3];
    int          below_acc [2][3];
    int          col_cnt;
    int          row_cnt;
    logic [12:0] cfg_width;
    logic [15:0] cfg_height;
    logic [8:0]  cfg_pal;

    fsd_out_t    expected_indices [$];
    fsd_out_t    want;
    int          error_count = 0;
    int          items_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    floyd_steinberg_palette_dither_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_indices.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result word: index %0d row_end %0b image_end %0b",
                             m_data.palette_index, m_data.row_end, m_data.image_end);
                error_count++;
            end else begin
                want = expected_indices.pop_front();
                if (m_data.palette_index !== want.palette_index ||
                    m_data.row_end !== want.row_end ||
                    m_data.image_end !== want.image_end) begin
                    if (error_count < 10)
                        $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 want.palette_index, want.row_end, want.image_end,
                                 m_data.palette_index, m_data.row_end, m_data.image_end);
                    error_count++;
                end
            end
        end
    end

    task automatic predict_dither(fsd_in_t wd);
        int w, h, n, x, best, best_d, d, v, cur;
        int c [3];
        int e [3];
        int px [3];
        bit last_col, last_row;
        fsd_out_t res;
        if (wd.cmd == CMD_PALETTE) begin
            pal_rgb[wd.entry_index][0] = wd.red;
            pal_rgb[wd.entry_index][1] = wd.green;
            pal_rgb[wd.entry_index][2] = wd.blue;
        end else begin
            w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
            h = (cfg_height == 0) ? 1 : int'(cfg_height);
            n = (cfg_pal == 0) ? 1 : ((cfg_pal > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(cfg_pal));
            x = (col_cnt >= w) ? w - 1 : col_cnt;
            last_col = (col_cnt + 1 >= w);
            last_row = (row_cnt + 1 >= h);
            px[0] = int'(wd.red);
            px[1] = int'(wd.green);
            px[2] = int'(wd.blue);
            for (int ch = 0; ch < 3; ch++) begin
                v = px[ch] + carry_right[ch] + ((row_cnt != 0) ? err_row[x][ch] : 0);
                c[ch] = (v < 0) ? 0 : ((v > 255) ? 255 : v);
            end
            best = 0;
            best_d = 32'h7fff_ffff;
            for (int i = 0; i < n; i++) begin
                d = 0;
                for (int ch = 0; ch < 3; ch++) begin
                    v = c[ch] - int'(pal_rgb[i][ch]);
                    d += v * v;
                end
                if (d < best_d) begin
                    best_d = d;
                    best = i;
                end
            end
            for (int ch = 0; ch < 3; ch++) begin
                e[ch] = c[ch] - int'(pal_rgb[best][ch]);
                if (x > 0)
                    err_row[x - 1][ch] = below_acc[0][ch] + (e[ch] * 3) / 16;
                cur = below_acc[1][ch] + (e[ch] * 5) / 16;
                if (last_col) begin
                    err_row[x][ch] = cur;
                    carry_right[ch] = 0;
                    below_acc[0][ch] = 0;
                    below_acc[1][ch] = 0;
                end else begin
                    carry_right[ch] = (e[ch] * 7) / 16;
                    below_acc[0][ch] = cur;
                    below_acc[1][ch] = e[ch] / 16;
                end
            end
            if (last_col) begin
                col_cnt = 0;
                row_cnt = last_row ? 0 : ((row_cnt + 1) & 16'hffff);
            end else begin
                col_cnt = col_cnt + 1;
            end
            res.palette_index = 8'(best);
            res.row_end = last_col;
            res.image_end = last_col && last_row;
            expected_indices.push_back(res);
        end
    endtask

    function automatic logic [7:0] rand_level();
        int k;
        k = $urandom_range(7);
        if (k == 0)
            return 8'd0;
        if (k == 1)
            return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    function automatic fsd_in_t pixel_word(logic [23:0] rgb);
        fsd_in_t p;
        p.cmd = CMD_PIXEL;
        p.entry_index = 8'($urandom_range(255));
        {p.red, p.green, p.blue} = rgb;
        return p;
    endfunction

    function automatic fsd_in_t rand_pixel();
        return pixel_word({rand_level(), rand_level(), rand_level()});
    endfunction

    function automatic fsd_in_t palette_word(logic [7:0] idx, logic [23:0] rgb);
        fsd_in_t p;
        p.cmd = CMD_PALETTE;
        p.entry_index = idx;
        {p.red, p.green, p.blue} = rgb;
        return p;
    endfunction

    task automatic send_word(fsd_in_t wd);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = wd;
        do @(posedge aclk); while (!s_ready);
        predict_dither(wd);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_indices.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width = val[12:0];
            REG_IMAGE_HEIGHT: cfg_height = val[15:0];
            REG_PALETTE_SIZE: cfg_pal = val[8:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int w, int h, int p);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 32'(w));
        write_reg(REG_IMAGE_HEIGHT, 32'(h));
        write_reg(REG_PALETTE_SIZE, 32'(p));
    endtask

    task automatic load_palette(int lo, int hi);
        for (int i = lo; i <= hi; i++)
            send_word(palette_word(8'(i), 24'($urandom)));
    endtask

    task automatic finish_image();
        while (col_cnt != 0 || row_cnt != 0)
            send_word(rand_pixel());
    endtask

    // reset config, duplicate entries for the tie rule, then a width cut mid-row
    task automatic test_defaults();
        send_word(palette_word(8'd0, 24'h000000));
        send_word(palette_word(8'd1, 24'hffffff));
        send_word(palette_word(8'd2, 24'hffffff));
        send_word(palette_word(8'd3, 24'hff0000));
        send_word(palette_word(8'd4, 24'h00ff00));
        send_word(palette_word(8'd5, 24'h0000ff));
        load_palette(6, 15);
        send_word(pixel_word(24'h000000));
        send_word(pixel_word(24'hffffff));
        send_word(pixel_word(24'h010101));
        send_word(pixel_word(24'h7f8081));
        set_config(2, 2, 16);
        finish_image();
    endtask

    task automatic test_tiny_images();
        set_config(0, 0, 0);
        send_word(pixel_word(24'hffffff));
        send_word(pixel_word(24'h000000));
        send_word(rand_pixel());
        set_config(1, 3, 2);
        repeat (3) send_word(rand_pixel());
    endtask

    task automatic test_full_palette();
        load_palette(16, PALETTE_DEPTH - 1);
        set_config(3, 2, 511);
        send_word(pixel_word(24'h000000));
        send_word(pixel_word(24'hffffff));
        repeat (4) send_word(rand_pixel());
        set_config(3, 2, PALETTE_DEPTH);
        repeat (6) send_word(rand_pixel());
    endtask

    // height cut after three rows ends the image at the next row end
    task automatic test_tall_image();
        set_config(3, 65535, 8);
        repeat (9) send_word(rand_pixel());
        set_config(3, 2, 8);
        finish_image();
    endtask

    task automatic test_random_images(int target);
        int stop_at, k, w, h, p, npix, cut;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            k = $urandom_range(9);
            w = (k < 6) ? $urandom_range(6, 1) :
                ((k < 9) ? $urandom_range(24, 7) : $urandom_range(64, 25));
            h = $urandom_range(5, 1);
            k = $urandom_range(19);
            p = (k < 14) ? $urandom_range(32, 1) :
                ((k < 19) ? $urandom_range(256, 33) : $urandom_range(511, 257));
            set_config(w, h, p);
            npix = w * h;
            cut = ($urandom_range(7) == 0) ? $urandom_range(npix - 1, 0) : npix;
            for (int i = 0; i < cut; i++) begin
                if ($urandom_range(9) == 0)
                    send_word(palette_word(8'($urandom_range(255)), 24'($urandom)));
                send_word(rand_pixel());
            end
            // width may only shrink mid-image
            if (cut < npix)
                set_config($urandom_range(w, 1), $urandom_range(6, 1), p);
            finish_image();
        end
    endtask

    // oversized width register, then a width cut that ends the long row
    task automatic test_widest_row();
        set_config(8191, 1, 2);
        repeat (60) send_word(rand_pixel());
        set_config(7, 1, 2);
        finish_image();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_width = 13'd640;
        cfg_height = 16'd480;
        cfg_pal = 9'd16;
        col_cnt = 0;
        row_cnt = 0;
        for (int ch = 0; ch < 3; ch++) begin
            carry_right[ch] = 0;
            below_acc[0][ch] = 0;
            below_acc[1][ch] = 0;
        end
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        tx_idle_pct = 23;
        rx_idle_pct = 65;
        test_defaults();
        test_tiny_images();
        test_full_palette();
        test_tall_image();
        test_random_images(180);

        tx_idle_pct = 65;
        rx_idle_pct = 23;
        test_random_images(180);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_images(180);
        test_widest_row();

        wait_drained();
        if (error_count == 0)
            $display("tb_floyd_steinberg_palette_dither_top OK");
        else
            $display("tb_floyd_steinberg_palette_dither_top NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_floyd_steinberg_palette_dither_top NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/fsd_pkg.sv
rtl/floyd_steinberg_palette_dither_top.sv
tb/sv/tb_floyd_steinberg_palette_dither_top.sv
